### rtl/pdbf_pkg.sv
// Shared types and constants for the pattern-deleting byte filter.
`default_nettype none

package pdbf_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 5;
    localparam int WORD_W  = 64;
    localparam int PAT_W   = 2 * WORD_W;
    localparam int ADDR_W  = 5;
    localparam int INDEX_W = 2;

    // Register indexes on the configuration port
    localparam logic [INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [INDEX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    // Register contents seen by the datapath
    typedef struct packed {
        logic [LEN_W-1:0] pattern_length;
        logic [PAT_W-1:0] pattern_bytes;
        logic             length_written;
    } t_cfg;

    // Controls broadcast to every window cell
    typedef struct packed {
        logic             load;
        logic             shift;
        logic [LEN_W-1:0] fill;
        logic [LEN_W-1:0] len;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### rtl/pdbf_in_if.sv
// Input channel: one stream byte per beat with a last marker.
`default_nettype none

interface pdbf_in_if;
    import pdbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

### rtl/pdbf_out_if.sv
// Output channel: one kept byte or an empty end marker per beat.
`default_nettype none

interface pdbf_out_if;
    import pdbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_has_byte;
    logic              out_last;

    modport source (output valid, output out_byte, output out_has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_has_byte, input out_last,
                    output ready);
endinterface

`default_nettype wire

### rtl/pattern_deleting_byte_filter.sv
// Top level of the pattern-deleting byte filter.
// Deletes every leftmost, non-overlapping occurrence of a pattern of up to MAX_PATTERN
// bytes (set over the APB port at 8*index: length, bytes 0-7, bytes 8-15) from a byte
// stream. The window is a row of MAX_PATTERN cells that compare in parallel, so one
// byte is taken every cycle while the output beat register drains. A byte that is not
// last gives zero or one output beat, registered as the byte is taken. A last byte gives
// its first beat at once and then flushes the remaining window bytes with the input held
// off, one per cycle while the output beat register drains. A stream that ends with
// nothing left to send gives one beat without a byte, marked last. Pattern length zero
// passes bytes straight through; a length above MAX_PATTERN is treated as MAX_PATTERN.
// Writing the length empties the window.
`default_nettype none

module pattern_deleting_byte_filter
    import pdbf_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready,
    pdbf_in_if.sink                i_in,
    pdbf_out_if.source             o_out
);

    t_cfg              cfg;
    t_cell_ctrl        ctrl;
    logic [BYTE_W-1:0] cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_equal;

    logic [LEN_W-1:0]  r_fill;
    logic [LEN_W-1:0]  n_fill;
    logic              r_flush;
    logic              n_flush;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_has_byte;
    logic              r_out_last;

    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  fill_inc;
    logic              slot_free;
    logic              accept;
    logic              full;
    logic              match;
    logic              shift;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_has_byte;
    logic              emit_last;

    pdbf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Clamp the length to the window depth
    assign len_eff  = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                                  : cfg.pattern_length;
    assign fill_inc = r_fill + LEN_W'(1);

    assign slot_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_flush && slot_free;
    assign accept     = i_in.valid && i_in.ready;

    // Row of window cells, oldest byte in cell 0
    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            logic [BYTE_W-1:0] right_byte;
            if (g == MAX_PATTERN - 1) begin : g_end
                assign right_byte = '0;
            end else begin : g_mid
                assign right_byte = cell_byte[g+1];
            end
            pdbf_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (ctrl),
                .i_new_byte     (i_in.in_byte),
                .i_right_byte   (right_byte),
                .i_pattern_byte (cfg.pattern_bytes[g*BYTE_W +: BYTE_W]),
                .o_byte         (cell_byte[g]),
                .o_equal        (cell_equal[g])
            );
        end
    endgenerate

    assign full  = fill_inc == len_eff;
    assign match = full && (&cell_equal);

    // Decide what this cycle emits and how the window moves
    always_comb begin
        shift         = 1'b0;
        emit          = 1'b0;
        emit_byte     = cell_byte[0];
        emit_has_byte = 1'b1;
        emit_last     = 1'b0;
        n_fill        = r_fill;
        n_flush       = r_flush;
        if (accept) begin
            if (len_eff == '0) begin
                // pass through
                emit      = 1'b1;
                emit_byte = i_in.in_byte;
                emit_last = i_in.in_last;
                n_fill    = '0;
            end else if (match) begin
                // drop the whole window
                n_fill        = '0;
                emit          = i_in.in_last;
                emit_byte     = '0;
                emit_has_byte = 1'b0;
                emit_last     = 1'b1;
            end else if (full || i_in.in_last) begin
                // send the oldest byte and advance
                emit      = 1'b1;
                shift     = 1'b1;
                n_fill    = r_fill;
                emit_last = i_in.in_last && (r_fill == '0);
                n_flush   = i_in.in_last && (r_fill != '0);
            end else begin
                n_fill = fill_inc;
            end
        end else if (r_flush && slot_free) begin
            // flush one held byte
            emit      = 1'b1;
            shift     = 1'b1;
            emit_last = r_fill == LEN_W'(1);
            n_fill    = r_fill - LEN_W'(1);
            n_flush   = r_fill != LEN_W'(1);
        end
        if (cfg.length_written) begin
            n_fill  = '0;
            n_flush = 1'b0;
        end
    end

    assign ctrl.load  = accept;
    assign ctrl.shift = shift;
    assign ctrl.fill  = r_fill;
    assign ctrl.len   = len_eff;

    // Hold window state and the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_flush <= n_flush;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte     <= emit_byte;
            r_out_has_byte <= emit_has_byte;
            r_out_last     <= emit_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.out_has_byte = r_out_has_byte;
    assign o_out.out_last     = r_out_last;

endmodule

`default_nettype wire

### rtl/pdbf_cfg.sv
// APB-style register file holding the pattern length and pattern bytes.
`default_nettype none

module pdbf_cfg
    import pdbf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [LEN_W-1:0]   r_pattern_length;
    logic [WORD_W-1:0]  r_pattern_low;
    logic [WORD_W-1:0]  r_pattern_high;
    logic [INDEX_W-1:0] reg_index;
    logic               wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:ADDR_W-INDEX_W];
    assign wr_en     = psel & penable & pwrite & pready;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
        end else if (wr_en) begin
            case (reg_index)
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[LEN_W-1:0];
                REG_PATTERN_LOW:    r_pattern_low    <= pwdata;
                REG_PATTERN_HIGH:   r_pattern_high   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_index)
            REG_PATTERN_LENGTH: prdata = {{(WORD_W-LEN_W){1'b0}}, r_pattern_length};
            REG_PATTERN_LOW:    prdata = r_pattern_low;
            REG_PATTERN_HIGH:   prdata = r_pattern_high;
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.pattern_length = r_pattern_length;
    assign o_cfg.pattern_bytes  = {r_pattern_high, r_pattern_low};
    assign o_cfg.length_written = wr_en & (reg_index == REG_PATTERN_LENGTH);

endmodule

`default_nettype wire

### rtl/pdbf_cell.sv
// One window cell: holds a byte, compares it with its pattern byte, shifts left.
`default_nettype none

module pdbf_cell
    import pdbf_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [BYTE_W-1:0] i_new_byte,
    input  wire logic [BYTE_W-1:0] i_right_byte,
    input  wire logic [BYTE_W-1:0] i_pattern_byte,
    output logic      [BYTE_W-1:0] o_byte,
    output logic                   o_equal
);

    logic [BYTE_W-1:0] r_byte;
    logic              is_tail;
    logic              in_window;

    assign is_tail   = i_ctrl.fill == LEN_W'(IDX);
    assign in_window = LEN_W'(IDX) < i_ctrl.len;

    // Window content including the incoming byte at the tail slot
    assign o_byte  = (i_ctrl.load && is_tail) ? i_new_byte : r_byte;
    assign o_equal = !in_window || (o_byte == i_pattern_byte);

    // Take the neighbor's byte on a shift, else latch the new byte at the tail
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_right_byte;
        end else if (i_ctrl.load) begin
            r_byte <= o_byte;
        end
    end

endmodule

`default_nettype wire
